// ===== design/mqw_pkg.sv =====
// shared types and constants for the message queue with waiters
`default_nettype none
package mqw_pkg;

   // fixed field widths
   localparam int FUNC_WIDTH  = 2;
   localparam int PRIO_WIDTH  = 5;
   localparam int WORD_WIDTH  = 32;
   localparam int STAT_WIDTH  = 3;
   localparam int QSIZE_WIDTH = 5;

   // reset value of the queue size register
   localparam logic [QSIZE_WIDTH-1:0] QSIZE_RESET = 5'd16;

   // operation codes
   localparam logic [FUNC_WIDTH-1:0] FUNC_POST    = 2'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_PEND    = 2'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_TIMEOUT = 2'd2;

   // result status codes
   localparam logic [STAT_WIDTH-1:0] STATUS_OK      = 3'd0;
   localparam logic [STAT_WIDTH-1:0] STATUS_FULL    = 3'd1;
   localparam logic [STAT_WIDTH-1:0] STATUS_TIMEOUT = 3'd2;
   localparam logic [STAT_WIDTH-1:0] STATUS_BLOCKED = 3'd3;
   localparam logic [STAT_WIDTH-1:0] STATUS_ISR     = 3'd4;

   // request word
   typedef struct packed {
      logic [FUNC_WIDTH-1:0] func;
      logic [PRIO_WIDTH-1:0] task_prio;
      logic [WORD_WIDTH-1:0] msg;
      logic                  from_isr;
   } req_type;

   // response word
   typedef struct packed {
      logic [STAT_WIDTH-1:0] status;
      logic [WORD_WIDTH-1:0] msg_out;
      logic                  wake_valid;
      logic [PRIO_WIDTH-1:0] wake_prio;
   } rsp_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

endpackage
`default_nettype wire

// ===== design/message_queue_with_waiters.sv =====
// top level of the message queue with a bitmap of waiting tasks
//
//   channel   ports                        handshake
//   request   start, busy, req_data        taken when start && !busy
//   response  rsp_valid, rsp_data          one-cycle strobe, always taken
//   csr       csr_wr_en, csr_wr_data       queue size, written when csr_wr_en
//
// every word goes through two steps: capture takes it and reads the ring
// head, execute updates the store, indexes and wait mask; the response shows
// in the cycle after execute, while busy is already low for the next word.
// reset clears indexes, count and wait mask and sets the queue size to 16;
// store contents are not cleared. the response side cannot stall.
`default_nettype none
module message_queue_with_waiters #(
   parameter int QDEPTH    = 16,
   parameter int NUM_PRIO  = 32,
   parameter int MSG_WIDTH = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire mqw_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   output mqw_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_wr_en,
   input  wire logic [mqw_pkg::QSIZE_WIDTH-1:0] csr_wr_data
);

   mqw_pkg::cmd_type cmd;

   // controller
   mqw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // datapath
   mqw_dp #(
      .QDEPTH    (QDEPTH),
      .NUM_PRIO  (NUM_PRIO),
      .MSG_WIDTH (MSG_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   // a response never shows while a word is still in work
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("response strobe while busy");

   // an accepted word is worked on next cycle with no stray response
   assert property (@(posedge clock) disable iff (reset)
                    (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted word not taken into work");

   // each word in work gives exactly one response
   assert property (@(posedge clock) disable iff (reset) busy |=> rsp_valid)
      else $error("missing response after work cycle");

   // responses only follow a work cycle
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid |-> $past(cmd.execute))
      else $error("response without work cycle");

endmodule
`default_nettype wire

// ===== design/mqw_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none
module mqw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ===== design/mqw_ctrl.sv =====
// controller state machine for the message queue
`default_nettype none
module mqw_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   output mqw_pkg::cmd_type     cmd
);

   mqw_pkg::state_type state_ff;
   mqw_pkg::state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mqw_pkg::ST_IDLE: begin
            if (start) begin
               state_in = mqw_pkg::ST_EXEC;
            end
         end
         mqw_pkg::ST_EXEC: begin
            state_in = mqw_pkg::ST_IDLE;
         end
         default: begin
            state_in = mqw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mqw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands to the datapath
   assign busy        = (state_ff == mqw_pkg::ST_EXEC);
   assign cmd.capture = (state_ff == mqw_pkg::ST_IDLE) && start;
   assign cmd.execute = (state_ff == mqw_pkg::ST_EXEC);

endmodule
`default_nettype wire

// ===== design/mqw_dp.sv =====
// datapath: ring store, wait mask, indexes and response register
`default_nettype none
module mqw_dp #(
   parameter int QDEPTH    = 16,
   parameter int NUM_PRIO  = 32,
   parameter int MSG_WIDTH = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire mqw_pkg::cmd_type                       cmd,
   input  wire mqw_pkg::req_type                       req_data,
   input  wire logic                                   csr_wr_en,
   input  wire logic [mqw_pkg::QSIZE_WIDTH-1:0]        csr_wr_data,
   output logic                                        rsp_valid,
   output mqw_pkg::rsp_type                            rsp_data
);

   localparam int IW   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CW   = $clog2(QDEPTH + 1);
   localparam int CAPW = (CW > mqw_pkg::QSIZE_WIDTH) ? CW : mqw_pkg::QSIZE_WIDTH;
   localparam int XW   = CAPW + 1;
   localparam int PW   = $clog2(NUM_PRIO);

   mqw_pkg::req_type                  req_ff;
   logic [mqw_pkg::QSIZE_WIDTH-1:0]   qsize_ff;
   logic [IW-1:0]                     rd_idx_ff, rd_idx_in;
   logic [IW-1:0]                     wr_idx_ff, wr_idx_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [NUM_PRIO-1:0]               mask_ff, mask_in;
   logic                              rsp_valid_ff;
   mqw_pkg::rsp_type                  rsp_ff, rsp_in;

   logic                              ram_we;
   logic [MSG_WIDTH-1:0]              ram_rdata;
   logic [CAPW-1:0]                   cap;
   logic [NUM_PRIO-1:0]               prio_bit;
   logic [PW-1:0]                     low_idx;

   // index step: wrap to zero at or beyond the capacity
   function automatic logic [IW-1:0] step_idx(input logic [IW-1:0] idx,
                                              input logic [CAPW-1:0] c);
      logic [XW-1:0] ix;
      logic [XW-1:0] cx;
      ix = XW'(idx);
      cx = XW'(c);
      if ((ix >= cx) || ((ix + XW'(1)) >= cx)) begin
         return '0;
      end
      return idx + IW'(1);
   endfunction

   // capacity is the smaller of the size register and the store depth
   assign cap = (CAPW'(qsize_ff) < CAPW'(QDEPTH)) ? CAPW'(qsize_ff) : CAPW'(QDEPTH);

   // wait bit of the request priority, none when out of range
   always_comb begin
      prio_bit = '0;
      if (32'(req_ff.task_prio) < 32'(NUM_PRIO)) begin
         prio_bit = NUM_PRIO'(1) << req_ff.task_prio;
      end
   end

   // lowest waiting priority
   always_comb begin
      low_idx = '0;
      for (int i = NUM_PRIO - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            low_idx = PW'(i);
         end
      end
   end

   // operation decode and state update
   always_comb begin
      rd_idx_in = rd_idx_ff;
      wr_idx_in = wr_idx_ff;
      count_in  = count_ff;
      mask_in   = mask_ff;
      ram_we    = 1'b0;
      rsp_in    = '0;
      case (req_ff.func)
         mqw_pkg::FUNC_POST: begin
            if (mask_ff != '0) begin
               mask_in           = mask_ff & ~(NUM_PRIO'(1) << low_idx);
               rsp_in.msg_out    = mqw_pkg::WORD_WIDTH'(MSG_WIDTH'(req_ff.msg));
               rsp_in.wake_valid = 1'b1;
               rsp_in.wake_prio  = mqw_pkg::PRIO_WIDTH'(low_idx);
            end else if (CAPW'(count_ff) >= cap) begin
               rsp_in.status = mqw_pkg::STATUS_FULL;
            end else begin
               ram_we    = 1'b1;
               wr_idx_in = step_idx(wr_idx_ff, cap);
               count_in  = count_ff + CW'(1);
            end
         end
         mqw_pkg::FUNC_PEND: begin
            if (req_ff.from_isr) begin
               rsp_in.status = mqw_pkg::STATUS_ISR;
            end else if (count_ff != '0) begin
               rsp_in.msg_out = mqw_pkg::WORD_WIDTH'(ram_rdata);
               rd_idx_in      = step_idx(rd_idx_ff, cap);
               count_in       = count_ff - CW'(1);
            end else begin
               mask_in       = mask_ff | prio_bit;
               rsp_in.status = mqw_pkg::STATUS_BLOCKED;
            end
         end
         mqw_pkg::FUNC_TIMEOUT: begin
            mask_in       = mask_ff & ~prio_bit;
            rsp_in.status = mqw_pkg::STATUS_TIMEOUT;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   // ring store, read at the read index every cycle
   mqw_ram #(
      .WIDTH (MSG_WIDTH),
      .DEPTH (QDEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.execute && ram_we),
      .wr_addr (wr_idx_ff),
      .wr_data (MSG_WIDTH'(req_ff.msg)),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rdata)
   );

   // request and response payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         qsize_ff     <= mqw_pkg::QSIZE_RESET;
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         count_ff     <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            qsize_ff <= csr_wr_data;
         end
         if (cmd.execute) begin
            rd_idx_ff <= rd_idx_in;
            wr_idx_ff <= wr_idx_in;
            count_ff  <= count_in;
            mask_ff   <= mask_in;
         end
         rsp_valid_ff <= cmd.execute;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== bench/message_queue_with_waiters_tb.sv =====
// self-checking testbench for the message queue with waiters
module message_queue_with_waiters_tb;
   import mqw_pkg::*;

   localparam int RING_DEPTH = 16;
   localparam int PRIO_COUNT = 32;
   localparam int PHASE_WORDS = 95;
   localparam int IDLE_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 8;

   // code that the block must treat as a no-op
   localparam logic [FUNC_WIDTH-1:0] FUNC_SPARE = 2'd3;

   // one line of the directed script: a word or a queue size write
   typedef struct packed {
      logic                   is_csr;
      logic [QSIZE_WIDTH-1:0] csr_value;
      req_type                call;
      logic                   typed;
      rsp_type                reply;
   } script_row;

   localparam script_row DIRECTED_STEPS [0:23] = '{
      '{1'b0, 5'd0, '{FUNC_PEND, 5'd0, 32'h0, 1'b0}, 1'b1,
        '{STATUS_BLOCKED, 32'h0, 1'b0, 5'd0}},
      '{1'b0, 5'd0, '{FUNC_PEND, 5'd31, 32'h0, 1'b0}, 1'b1,
        '{STATUS_BLOCKED, 32'h0, 1'b0, 5'd0}},
      '{1'b0, 5'd0, '{FUNC_PEND, 5'd5, 32'h0, 1'b1}, 1'b1,
        '{STATUS_ISR, 32'h0, 1'b0, 5'd0}},
      '{1'b0, 5'd0, '{FUNC_POST, 5'd0, 32'hFFFF_FFFF, 1'b0}, 1'b1,
        '{STATUS_OK, 32'hFFFF_FFFF, 1'b1, 5'd0}},
      '{1'b0, 5'd0, '{FUNC_TIMEOUT, 5'd31, 32'h0, 1'b0}, 1'b1,
        '{STATUS_TIMEOUT, 32'h0, 1'b0, 5'd0}},
      '{1'b0, 5'd0, '{FUNC_TIMEOUT, 5'd7, 32'h0, 1'b1}, 1'b1,
        '{STATUS_TIMEOUT, 32'h0, 1'b0, 5'd0}},
      '{1'b0, 5'd0, '{FUNC_POST, 5'd0, 32'h0, 1'b0}, 1'b1,
        '{STATUS_OK, 32'h0, 1'b0, 5'd0}},
      '{1'b0, 5'd0, '{FUNC_POST, 5'd0, 32'hA5A5_5A5A, 1'b0}, 1'b1,
        '{STATUS_OK, 32'h0, 1'b0, 5'd0}},
      '{1'b0, 5'd0, '{FUNC_PEND, 5'd3, 32'h0, 1'b1}, 1'b1,
        '{STATUS_ISR, 32'h0, 1'b0, 5'd0}},
      '{1'b0, 5'd0, '{FUNC_PEND, 5'd3, 32'h0, 1'b0}, 1'b1,
        '{STATUS_OK, 32'h0, 1'b0, 5'd0}},
      '{1'b0, 5'd0, '{FUNC_PEND, 5'd3, 32'h0, 1'b0}, 1'b1,
        '{STATUS_OK, 32'hA5A5_5A5A, 1'b0, 5'd0}},
      '{1'b0, 5'd0, '{FUNC_SPARE, 5'd31, 32'hFFFF_FFFF, 1'b1}, 1'b1,
        '{STATUS_OK, 32'h0, 1'b0, 5'd0}},
      '{1'b1, 5'd1, '0, 1'b0, '0},
      '{1'b0, 5'd0, '{FUNC_POST, 5'd0, 32'h1234_5678, 1'b0}, 1'b1,
        '{STATUS_OK, 32'h0, 1'b0, 5'd0}},
      '{1'b0, 5'd0, '{FUNC_POST, 5'd0, 32'hDEAD_BEEF, 1'b0}, 1'b1,
        '{STATUS_FULL, 32'h0, 1'b0, 5'd0}},
      '{1'b1, 5'd0, '0, 1'b0, '0},
      '{1'b0, 5'd0, '{FUNC_POST, 5'd0, 32'h0000_0001, 1'b0}, 1'b1,
        '{STATUS_FULL, 32'h0, 1'b0, 5'd0}},
      '{1'b0, 5'd0, '{FUNC_PEND, 5'd9, 32'h0, 1'b0}, 1'b1,
        '{STATUS_OK, 32'h1234_5678, 1'b0, 5'd0}},
      '{1'b0, 5'd0, '{FUNC_PEND, 5'd9, 32'h0, 1'b0}, 1'b1,
        '{STATUS_BLOCKED, 32'h0, 1'b0, 5'd0}},
      '{1'b0, 5'd0, '{FUNC_POST, 5'd0, 32'h8000_0000, 1'b0}, 1'b1,
        '{STATUS_OK, 32'h8000_0000, 1'b1, 5'd9}},
      '{1'b1, 5'd31, '0, 1'b0, '0},
      '{1'b0, 5'd0, '{FUNC_POST, 5'd17, 32'h5A5A_A5A5, 1'b1}, 1'b0, '0},
      '{1'b0, 5'd0, '{FUNC_PEND, 5'd30, 32'h0, 1'b0}, 1'b0, '0},
      '{1'b1, 5'd16, '0, 1'b0, '0}
   };

   // queue sizes of the random phases
   localparam logic [QSIZE_WIDTH-1:0] PHASE_SIZES [0:9] = '{
      5'd1, 5'd16, 5'd2, 5'd0, 5'd31, 5'd4, 5'd8, 5'd3, 5'd12, 5'd16
   };

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_data;
   logic                   rsp_valid;
   rsp_type                rsp_data;
   logic                   csr_wr_en;
   logic [QSIZE_WIDTH-1:0] csr_wr_data;

   // mirror of the queue state
   logic [WORD_WIDTH-1:0]  ring_words [RING_DEPTH];
   logic                   ring_filled [RING_DEPTH];
   int unsigned            head_idx;
   int unsigned            tail_idx;
   int unsigned            word_count;
   logic [PRIO_COUNT-1:0]  waiter_bits;
   logic [QSIZE_WIDTH-1:0] size_reg;

   rsp_type                outstanding_replies [$];
   int unsigned            mismatch_count;
   int unsigned            idle_cycles;
   int unsigned            burst_left;

   message_queue_with_waiters #(
      .QDEPTH    (RING_DEPTH),
      .NUM_PRIO  (PRIO_COUNT),
      .MSG_WIDTH (WORD_WIDTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // usable slots, never more than the ring holds
   function automatic int unsigned ring_capacity();
      return (size_reg < RING_DEPTH) ? int'(size_reg) : RING_DEPTH;
   endfunction

   // wrap to slot 0 at the end of the used part, or when already past it
   function automatic int unsigned step_slot(input int unsigned idx);
      int unsigned cap;
      cap = ring_capacity();
      if (idx >= cap || idx + 1 >= cap) return 0;
      return idx + 1;
   endfunction

   // apply one kernel call to the mirror and return its reply
   function automatic rsp_type apply_kernel_call(input req_type call);
      rsp_type               reply;
      logic [PRIO_COUNT-1:0] prio_bit;
      int                    woken;
      reply = '0;
      prio_bit = {{(PRIO_COUNT-1){1'b0}}, 1'b1} << call.task_prio;
      woken = 0;
      case (call.func)
         FUNC_POST: begin
            if (waiter_bits != '0) begin
               for (int p = PRIO_COUNT - 1; p >= 0; p--)
                  if (waiter_bits[p]) woken = p;
               waiter_bits[woken] = 1'b0;
               reply.msg_out = call.msg;
               reply.wake_valid = 1'b1;
               reply.wake_prio = woken[PRIO_WIDTH-1:0];
            end else if (word_count >= ring_capacity()) begin
               reply.status = STATUS_FULL;
            end else begin
               ring_words[tail_idx] = call.msg;
               ring_filled[tail_idx] = 1'b1;
               tail_idx = step_slot(tail_idx);
               word_count++;
            end
         end
         FUNC_PEND: begin
            if (call.from_isr) begin
               reply.status = STATUS_ISR;
            end else if (word_count != 0) begin
               reply.msg_out = ring_words[head_idx];
               head_idx = step_slot(head_idx);
               word_count--;
            end else begin
               waiter_bits |= prio_bit;
               reply.status = STATUS_BLOCKED;
            end
         end
         FUNC_TIMEOUT: begin
            waiter_bits &= ~prio_bit;
            reply.status = STATUS_TIMEOUT;
         end
         default: ;
      endcase
      return reply;
   endfunction

   // random kernel call, well formed most of the time
   function automatic req_type draw_kernel_call(input int unsigned post_weight);
      req_type     call;
      int unsigned roll;
      call.msg = $urandom();
      call.task_prio = PRIO_WIDTH'($urandom_range(0, PRIO_COUNT - 1));
      call.from_isr = ($urandom_range(0, 7) == 0);
      roll = $urandom_range(0, 99);
      if (roll < post_weight) call.func = FUNC_POST;
      else if (roll < 90) call.func = FUNC_PEND;
      else if (roll < 97) call.func = FUNC_TIMEOUT;
      else call.func = FUNC_SPARE;
      // timeouts mostly hit a task that is really waiting
      if (call.func == FUNC_TIMEOUT && waiter_bits != '0)
         for (int t = 0; t < 4 && !waiter_bits[call.task_prio]; t++)
            call.task_prio = PRIO_WIDTH'($urandom_range(0, PRIO_COUNT - 1));
      // a slot that was never written is never read
      if (call.func == FUNC_PEND && !call.from_isr && word_count != 0 &&
          !ring_filled[head_idx])
         call.func = FUNC_POST;
      return call;
   endfunction

   // sender gap, with runs of back-to-back words
   function automatic int unsigned draw_gap();
      if (burst_left != 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   // hand one word over and record what must come back
   task automatic issue_call(input req_type call, input int unsigned gap,
                             input logic typed, input rsp_type typed_reply);
      rsp_type predicted;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= call;
      start <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predicted = apply_kernel_call(call);
      outstanding_replies.push_back(typed ? typed_reply : predicted);
   endtask

   // stop sending until every reply is in
   task automatic settle_queue();
      if (outstanding_replies.size() != 0) begin
         start <= 1'b0;
         while (outstanding_replies.size() != 0) @(posedge clock);
      end
   endtask

   // queue size write, only while the block is idle
   task automatic set_queue_size(input logic [QSIZE_WIDTH-1:0] value);
      settle_queue();
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      size_reg = value;
      @(posedge clock);
   endtask

   // reply checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (outstanding_replies.size() == 0) begin
            $display("%0t: reply with none outstanding, actual %p", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = outstanding_replies.pop_front();
            if (rsp_data.status !== want.status ||
                rsp_data.msg_out !== want.msg_out ||
                rsp_data.wake_valid !== want.wake_valid ||
                rsp_data.wake_prio !== want.wake_prio) begin
               $display("%0t: status exp %0d act %0d, msg_out exp %h act %h", $time,
                        want.status, rsp_data.status, want.msg_out, rsp_data.msg_out);
               $display("%0t: wake_valid exp %b act %b, wake_prio exp %0d act %0d",
                        $time, want.wake_valid, rsp_data.wake_valid,
                        want.wake_prio, rsp_data.wake_prio);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles with no word moving either way
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // stimulus
   initial begin
      int unsigned post_weight;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = QSIZE_RESET;
      mismatch_count = 0;
      idle_cycles = 0;
      burst_left = 0;
      head_idx = 0;
      tail_idx = 0;
      word_count = 0;
      waiter_bits = '0;
      size_reg = QSIZE_RESET;
      for (int s = 0; s < RING_DEPTH; s++) begin
         ring_words[s] = '0;
         ring_filled[s] = 1'b0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed script
      foreach (DIRECTED_STEPS[r]) begin
         if (DIRECTED_STEPS[r].is_csr)
            set_queue_size(DIRECTED_STEPS[r].csr_value);
         else
            issue_call(DIRECTED_STEPS[r].call, $urandom_range(0, 19),
                       DIRECTED_STEPS[r].typed, DIRECTED_STEPS[r].reply);
      end

      // random phases, each at its own queue size and post/pend mix
      foreach (PHASE_SIZES[ph]) begin
         set_queue_size(PHASE_SIZES[ph]);
         post_weight = $urandom_range(20, 70);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(0, 99) == 0) settle_queue();
            issue_call(draw_kernel_call(post_weight), draw_gap(), 1'b0, '0);
         end
      end

      // drain and report
      settle_queue();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (outstanding_replies.size() != 0) mismatch_count++;
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== sim.f =====
design/mqw_pkg.sv
design/mqw_ram.sv
design/mqw_ctrl.sv
design/mqw_dp.sv
design/message_queue_with_waiters.sv
bench/message_queue_with_waiters_tb.sv
